### hdl/backlight_sleep_fade_controller_assert.svh
// Assertion macros for the backlight sleep fade controller.
`ifndef BACKLIGHT_SLEEP_FADE_CONTROLLER_ASSERT_SVH
`define BACKLIGHT_SLEEP_FADE_CONTROLLER_ASSERT_SVH
// Property that must hold in the cycle after a condition.
`define BSF_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |=> (b)) \
    else $error("bsf check failed");
// Property that must hold in the same cycle as a condition.
`define BSF_ASSERT_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |-> (b)) \
    else $error("bsf check failed");
`endif

### hdl/bsf_pkg.sv
// Package with constants, types and the sine table for the backlight controller.
package bsf_pkg;
  localparam int unsigned SineDepth = 256;
  localparam int unsigned SineIdxW = $clog2(SineDepth);
  localparam logic [10:0] Q10One = 11'd1024;
  localparam logic [16:0] Q16One = 17'd65536;
  localparam logic [32:0] WakeMargin = 33'd50;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  localparam logic [2:0] CfgTimeout = 3'd0;
  localparam logic [2:0] CfgWakeBr = 3'd1;
  localparam logic [2:0] CfgHasBl = 3'd2;
  localparam logic [2:0] CfgHasTouch = 3'd3;
  localparam logic [2:0] CfgHasButton = 3'd4;
  localparam logic [2:0] CfgHasOther = 3'd5;
  localparam logic [2:0] CfgManualDim = 3'd6;
  localparam logic [2:0] CfgTimeoutDim = 3'd7;

  localparam logic [1:0] KindTick = 2'd0;
  localparam logic [1:0] KindWake = 2'd1;
  localparam logic [1:0] KindSleep = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [31:0] now_ms;
    logic [31:0] inactive_ms;
    logic screen_locked;
    logic wake_pin;
  } in_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic power_saving;
    logic screen_blanked;
    logic touch_enabled;
    logic button_enabled;
    logic encoder_enabled;
    logic activity_pulse;
    logic sleep_started;
    logic [10:0] fade_progress;
    logic fade_is_wake;
  } out_t;

  typedef enum logic [1:0] {
    OpDiv = 2'd0,
    OpMul = 2'd1
  } op_e;

  typedef struct packed {
    logic start;
    op_e op;
    logic [31:0] a;
    logic [31:0] b;
  } ureq_t;

  typedef struct packed {
    logic done;
    logic [47:0] res;
  } ursp_t;

  function automatic logic [16:0] sine_entry(input int unsigned i);
    logic [63:0] x, term, sum, r;
    x = (64'(i) * HalfPiQ30) / 64'(SineDepth);
    term = x;
    sum = x;
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    r = (sum + 64'd8192) >> 14;
    return (r > 64'(Q16One)) ? Q16One : r[16:0];
  endfunction

  function automatic logic [16:0] sine_tab(input logic [SineIdxW:0] idx);
    logic [16:0] prev, v;
    prev = '0;
    v = '0;
    if (idx == (SineIdxW + 1)'(SineDepth)) return Q16One;
    for (int unsigned i = 1; i < SineDepth; i++) begin
      v = sine_entry(i);
      if (v < prev) v = prev;
      prev = v;
      if (i == 32'(idx)) return v;
    end
    return '0;
  endfunction
endpackage

### hdl/bsf_stream_if.sv
// Valid/ready stream interface for the controller channels.
interface bsf_stream_if #(parameter int unsigned W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/bsf_sine.sv
// Quarter-wave sine lookup with linear interpolation.
module bsf_sine (
  input  logic [10:0] p_i,
  output logic [16:0] s_o
);
  import bsf_pkg::*;
  logic [10:0] pc;
  logic [SineIdxW+10:0] pos;
  logic [SineIdxW:0] idx;
  logic [9:0] fr;
  logic [16:0] t0, t1;
  logic [26:0] dlt;
  always_comb begin
    pc = (p_i > Q10One) ? Q10One : p_i;
    pos = (SineIdxW + 11)'(pc) * (SineIdxW + 11)'(SineDepth);
    idx = pos[SineIdxW+10:10];
    fr = pos[9:0];
    t0 = sine_tab(idx);
    t1 = (idx >= (SineIdxW + 1)'(SineDepth)) ? Q16One : sine_tab(idx + 1'b1);
    dlt = 27'(t1 - t0) * 27'(fr);
    s_o = (idx >= (SineIdxW + 1)'(SineDepth)) ? Q16One : t0 + dlt[26:10];
  end
endmodule

### hdl/bsf_arith.sv
// Shared multi-cycle arithmetic unit: restoring divide and shift-add multiply.
module bsf_arith (
  input  logic clk_i,
  input  logic rst_ni,
  input  bsf_pkg::ureq_t req_i,
  output bsf_pkg::ursp_t rsp_o
);
  import bsf_pkg::*;
  logic busy_q, busy_d;
  op_e op_q, op_d;
  logic [5:0] cnt_q, cnt_d;
  logic [47:0] acc_q, acc_d;
  logic [47:0] rem_q, rem_d;
  logic [31:0] b_q, b_d;
  logic [47:0] a_q, a_d;
  logic done_q, done_d;
  logic [48:0] trial;

  always_comb begin
    busy_d = busy_q; op_d = op_q; cnt_d = cnt_q; acc_d = acc_q;
    rem_d = rem_q; b_d = b_q; a_d = a_q; done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      busy_d = 1'b1; op_d = req_i.op; cnt_d = 6'd0; acc_d = '0; rem_d = '0;
      b_d = req_i.b;
      a_d = (req_i.op == OpDiv) ? {req_i.a, 16'd0} : 48'(req_i.a);
    end else if (busy_q) begin
      case (op_q)
        OpDiv: begin
          trial = {rem_q, a_q[47]} - 49'(b_q);
          a_d = {a_q[46:0], 1'b0};
          if (!trial[48]) begin
            rem_d = trial[47:0]; acc_d = {acc_q[46:0], 1'b1};
          end else begin
            rem_d = {rem_q[46:0], a_q[47]}; acc_d = {acc_q[46:0], 1'b0};
          end
        end
        OpMul: begin
          if (b_q[0]) acc_d = acc_q + a_q;
          a_d = {a_q[46:0], 1'b0};
          b_d = {1'b0, b_q[31:1]};
        end
        default: ;
      endcase
      cnt_d = cnt_q + 6'd1;
      if ((op_q == OpDiv && cnt_q == 6'd47) || (op_q == OpMul && cnt_q == 6'd31)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; op_q <= OpDiv; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; op_q <= op_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; rem_q <= rem_d; b_q <= b_d; a_q <= a_d;
  end
  assign rsp_o.done = done_q;
  assign rsp_o.res = acc_q;
endmodule

### hdl/backlight_sleep_fade_controller.sv
// Top level of the backlight sleep fade controller with its sequencer.
// Usage: items enter on in_if (kind, now_ms, inactive_ms, screen_locked,
// wake_pin) and each gives exactly one beat on out_if. The user must see that
// registers are written through cfg_we_i, cfg_idx_i and cfg_data_i only while
// the block is idle; the block itself does not enforce it. A request beat goes
// from decide straight to finish. A tick can run progress divides and a level
// product, and a wake that joins a cancelled dim runs a ratio divide, an
// 11-step binary search over the sine table and a backdating multiply, all on
// one shared shift-subtract/shift-add unit.
// in_if is not ready while an item is in work or a result waits; one item
// at a time is handled.
// The result sits in an output register until out_if takes it; while the
// receiver stalls, no new beat is accepted.
// Reset clears the state to awake at level 255, touch on, no fade running,
// and loads the register reset values.
module backlight_sleep_fade_controller (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [26:0] cfg_data_i,
  bsf_stream_if.sink in_if,
  bsf_stream_if.source out_if
);
  import bsf_pkg::*;
  `include "backlight_sleep_fade_controller_assert.svh"

  typedef enum logic [10:0] {
    SIdle = 11'b00000000001, SDecide = 11'b00000000010, SDimProg = 11'b00000000100,
    SDimLvl = 11'b00000001000, SRatio = 11'b00000010000, SSearch = 11'b00000100000,
    SBack = 11'b00001000000, SWake = 11'b00010000000, SWakeLvl = 11'b00100000000,
    SFinish = 11'b01000000000, SOut = 11'b10000000000
  } state_e;

  state_e st_q, st_d;
  logic [26:0] tmo_q; logic [7:0] wbr_q; logic hbl_q, hto_q, hbu_q, hot_q;
  logic [15:0] mdim_q, tdim_q;
  logic saving_q, saving_d, wpend_q, wpend_d, spend_q, spend_d;
  logic blank_q, blank_d, touch_q, touch_d, button_q, button_d;
  logic dimrun_q, dimrun_d, wakerun_q, wakerun_d;
  logic [31:0] dstart_q, dstart_d, wstart_q, wstart_d;
  logic [7:0] dfrom_q, dfrom_d, level_q, level_d;
  logic [15:0] dlen_q, dlen_d;
  in_t it_q, it_d;
  out_t res_q, res_d;
  logic pulse_q, pulse_d, started_q, started_d, owake_q, owake_d;
  logic [10:0] prog_q, prog_d;
  logic target_q, target_d;
  logic [16:0] f_q, f_d;
  logic [10:0] lo_q, lo_d, hi_q, hi_d;
  logic issued_q, issued_d;
  logic outv_q, outv_d;
  ureq_t req;
  ursp_t rsp;
  logic [10:0] mid, sarg;
  logic [16:0] sval;
  logic [32:0] tmo33;
  logic should, awake;
  logic [7:0] tgt;
  logic [10:0] pq;

  bsf_arith u_arith (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));
  bsf_sine u_sine (.p_i(sarg), .s_o(sval));

  assign in_if.ready = (st_q == SIdle) && !outv_q;
  assign out_if.valid = outv_q;
  assign out_if.data = res_q;
  assign mid = 11'((12'(lo_q) + 12'(hi_q) + 12'd1) >> 1);
  assign tmo33 = 33'(tmo_q);
  assign tgt = target_q ? wbr_q : dfrom_q;
  assign pq = (rsp.res > 48'(Q10One)) ? Q10One : rsp.res[10:0];

  always_comb begin
    case (st_q)
      SDimLvl: sarg = Q10One - prog_q;
      SWakeLvl: sarg = prog_q;
      default: sarg = mid;
    endcase
  end

  always_comb begin
    st_d = st_q; saving_d = saving_q; wpend_d = wpend_q; spend_d = spend_q;
    blank_d = blank_q; touch_d = touch_q; button_d = button_q;
    dimrun_d = dimrun_q; wakerun_d = wakerun_q; dstart_d = dstart_q;
    wstart_d = wstart_q; dfrom_d = dfrom_q; level_d = level_q; dlen_d = dlen_q;
    it_d = it_q; res_d = res_q; pulse_d = pulse_q; started_d = started_q;
    owake_d = owake_q; prog_d = prog_q; target_d = target_q; f_d = f_q;
    lo_d = lo_q; hi_d = hi_q; issued_d = issued_q; outv_d = outv_q;
    req = '{start: 1'b0, op: OpDiv, a: '0, b: '0};
    should = 1'b0; awake = 1'b0;
    if (out_if.valid && out_if.ready) outv_d = 1'b0;
    case (st_q)
      SIdle: begin
        if (in_if.valid && in_if.ready) begin
          it_d = in_if.data; pulse_d = 1'b0; started_d = 1'b0; owake_d = 1'b0;
          prog_d = '0; issued_d = 1'b0;
          st_d = SDecide;
        end
      end
      SDecide: begin
        st_d = SFinish;
        if (it_q.kind == KindWake) wpend_d = 1'b1;
        else if (it_q.kind == KindSleep) spend_d = 1'b1;
        else if (it_q.kind == KindTick) begin
          should = (tmo_q != '0 && 33'(it_q.inactive_ms) > tmo33) || saving_q ||
                   it_q.screen_locked || spend_q;
          awake = (tmo33 + WakeMargin > 33'(it_q.inactive_ms)) &&
                  !it_q.screen_locked && !spend_q;
          if (should) begin
            if (hot_q || hto_q || hbu_q) begin
              if (hbl_q) begin
                if (!saving_q) begin
                  if (level_q == '0) begin
                    if (hto_q && hbu_q) begin touch_d = 1'b0; button_d = 1'b1; end
                    saving_d = 1'b1; prog_d = Q10One; owake_d = 1'b0;
                    if (it_q.wake_pin || awake || wpend_q) begin
                      saving_d = 1'b0; dimrun_d = 1'b0; wpend_d = 1'b0;
                      spend_d = 1'b0; level_d = '0; wstart_d = it_q.now_ms;
                      wakerun_d = 1'b1; pulse_d = 1'b1;
                      if (hto_q && hbu_q) begin touch_d = 1'b1; button_d = 1'b0; end
                    end
                  end else begin
                    if (!dimrun_q) begin
                      dimrun_d = 1'b1; dstart_d = it_q.now_ms; dfrom_d = level_q;
                      wakerun_d = 1'b0; wstart_d = '0;
                      dlen_d = (spend_q || it_q.screen_locked) ? mdim_q : tdim_q;
                      wpend_d = 1'b0;
                      started_d = 1'b1;
                    end
                    if (dimrun_q && wpend_q) begin
                      target_d = 1'b0; wpend_d = 1'b0; spend_d = 1'b0;
                      pulse_d = 1'b1; st_d = SRatio;
                    end else st_d = SDimProg;
                  end
                end else if (it_q.wake_pin || awake || wpend_q) begin
                  saving_d = 1'b0; dimrun_d = 1'b0; wpend_d = 1'b0;
                  spend_d = 1'b0; level_d = '0; wstart_d = it_q.now_ms;
                  wakerun_d = 1'b1; pulse_d = 1'b1;
                  if (hto_q && hbu_q) begin touch_d = 1'b1; button_d = 1'b0; end
                end
              end else begin
                if (!saving_q) begin blank_d = 1'b1; saving_d = 1'b1; end
                if (awake || wpend_q) begin
                  blank_d = 1'b0; saving_d = 1'b0; wpend_d = 1'b0;
                  spend_d = 1'b0; pulse_d = 1'b1;
                end
              end
            end
          end else if (level_q < wbr_q) begin
            if (!wakerun_q) begin target_d = 1'b1; st_d = SRatio; end
            else st_d = SWake;
          end
        end
      end
      SDimProg: begin
        if (!issued_q) begin
          req = '{start: 1'b1, op: OpDiv, a: it_q.now_ms - dstart_q, b: 32'(dlen_q)};
          issued_d = 1'b1;
          if (dlen_q == '0) begin prog_d = Q10One; issued_d = 1'b0; st_d = SDimLvl; end
        end else if (rsp.done) begin
          prog_d = 11'((rsp.res >> 6) > 48'(Q10One) ? 48'(Q10One) : rsp.res >> 6);
          issued_d = 1'b0; st_d = SDimLvl;
        end
      end
      SDimLvl: begin
        if (!issued_q) begin
          req = '{start: 1'b1, op: OpMul, a: 32'(dfrom_q), b: 32'(sval)};
          issued_d = 1'b1;
        end else if (rsp.done) begin
          level_d = rsp.res[23:16]; owake_d = 1'b0; issued_d = 1'b0; st_d = SFinish;
        end
      end
      SRatio: begin
        lo_d = '0; hi_d = Q10One;
        if (tgt == '0) begin f_d = '0; st_d = SSearch; end
        else if (!issued_q) begin
          req = '{start: 1'b1, op: OpDiv, a: 32'(level_q), b: 32'(tgt)};
          issued_d = 1'b1;
        end else if (rsp.done) begin
          f_d = (rsp.res > 48'(Q16One)) ? Q16One : rsp.res[16:0];
          issued_d = 1'b0; st_d = SSearch;
        end
      end
      SSearch: begin
        if (lo_q < hi_q) begin
          if (sval <= f_q) lo_d = mid; else hi_d = mid - 11'd1;
        end else st_d = SBack;
      end
      SBack: begin
        if (!issued_q) begin
          req = '{start: 1'b1, op: OpMul, a: 32'(lo_q), b: 32'(mdim_q)};
          issued_d = 1'b1;
        end else if (rsp.done) begin
          wstart_d = it_q.now_ms - 32'(rsp.res[47:10]);
          wakerun_d = 1'b1; dimrun_d = 1'b0; issued_d = 1'b0;
          st_d = target_q ? SWake : SFinish;
        end
      end
      SWake: begin
        dimrun_d = 1'b0; owake_d = 1'b1;
        if (!wakerun_q) begin
          level_d = wbr_q; prog_d = Q10One; st_d = SFinish;
        end else if (mdim_q == '0) begin
          level_d = wbr_q; wakerun_d = 1'b0; wstart_d = '0; prog_d = Q10One;
          st_d = SFinish;
        end else if (!issued_q) begin
          req = '{start: 1'b1, op: OpDiv, a: it_q.now_ms - wstart_q, b: 32'(mdim_q)};
          issued_d = 1'b1;
        end else if (rsp.done) begin
          issued_d = 1'b0;
          if ((rsp.res >> 6) >= 48'(Q10One)) begin
            level_d = wbr_q; wakerun_d = 1'b0; wstart_d = '0; prog_d = Q10One;
            st_d = SFinish;
          end else begin
            prog_d = 11'(rsp.res >> 6); st_d = SWakeLvl;
          end
        end
      end
      SWakeLvl: begin
        if (!issued_q) begin
          req = '{start: 1'b1, op: OpMul, a: 32'(wbr_q), b: 32'(sval)};
          issued_d = 1'b1;
        end else if (rsp.done) begin
          level_d = rsp.res[23:16]; issued_d = 1'b0; st_d = SFinish;
        end
      end
      SFinish: begin
        res_d = '{brightness: level_q, power_saving: saving_q, screen_blanked: blank_q,
                  touch_enabled: touch_q, button_enabled: button_q,
                  encoder_enabled: !saving_q, activity_pulse: pulse_q,
                  sleep_started: started_q, fade_progress: prog_q,
                  fade_is_wake: owake_q};
        outv_d = 1'b1; st_d = SOut;
      end
      SOut: begin
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; tmo_q <= '0; wbr_q <= 8'd255; hbl_q <= 1'b1; hto_q <= 1'b0;
      hbu_q <= 1'b0; hot_q <= 1'b0; mdim_q <= 16'd500; tdim_q <= 16'd2000;
      saving_q <= 1'b0; wpend_q <= 1'b0; spend_q <= 1'b0; blank_q <= 1'b0;
      touch_q <= 1'b1; button_q <= 1'b0; dimrun_q <= 1'b0; wakerun_q <= 1'b0;
      dstart_q <= '0; wstart_q <= '0; dfrom_q <= '0; level_q <= 8'd255;
      dlen_q <= '0; issued_q <= 1'b0; outv_q <= 1'b0;
    end else begin
      st_q <= st_d; saving_q <= saving_d; wpend_q <= wpend_d; spend_q <= spend_d;
      blank_q <= blank_d; touch_q <= touch_d; button_q <= button_d;
      dimrun_q <= dimrun_d; wakerun_q <= wakerun_d; dstart_q <= dstart_d;
      wstart_q <= wstart_d; dfrom_q <= dfrom_d; level_q <= level_d;
      dlen_q <= dlen_d; issued_q <= issued_d; outv_q <= outv_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTimeout: tmo_q <= cfg_data_i;
          CfgWakeBr: wbr_q <= cfg_data_i[7:0];
          CfgHasBl: hbl_q <= cfg_data_i[0];
          CfgHasTouch: hto_q <= cfg_data_i[0];
          CfgHasButton: hbu_q <= cfg_data_i[0];
          CfgHasOther: hot_q <= cfg_data_i[0];
          CfgManualDim: mdim_q <= cfg_data_i[15:0];
          CfgTimeoutDim: tdim_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; res_q <= res_d; pulse_q <= pulse_d; started_q <= started_d;
    owake_q <= owake_d; prog_q <= prog_d; target_q <= target_d; f_q <= f_d;
    lo_q <= lo_d; hi_q <= hi_d;
  end

  `BSF_ASSERT_NOW(a_out_ready_excl, clk_i, rst_ni, outv_q, !in_if.ready)
  `BSF_ASSERT_NOW(a_enc_vs_save, clk_i, rst_ni, outv_q,
                  res_q.encoder_enabled != res_q.power_saving)
  `BSF_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_if.valid && in_if.ready,
                   !in_if.ready)
endmodule
